// ===== design/lras_pkg.sv =====
// Shared types and constants for the line rasterizer.
`default_nettype none

package lras_pkg;

   // Default coordinate width and fixed colour width
   localparam int COORD_BITS_DEF = 10;
   localparam int COLOR_BITS     = 16;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH    = 2;

   // Item command codes
   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   // Per-axis step direction
   typedef enum logic [1:0] {
      DIR_NONE  = 2'd0,
      DIR_PLUS  = 2'd1,
      DIR_MINUS = 2'd3
   } dir_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

`default_nettype wire

// ===== design/lras_channels.sv =====
// Valid/ready channel interfaces for request items and pixel items.
`default_nettype none

interface lras_req_if
   import lras_pkg::*;
   #(parameter int COORD_BITS = COORD_BITS_DEF)
   ();
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] end_x;
   logic [COORD_BITS-1:0] end_y;
   logic [COLOR_BITS-1:0] pen_color;

   modport source (output valid, cmd, start_x, start_y, end_x, end_y, pen_color,
                   input ready);
   modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, pen_color,
                   output ready);
endinterface

interface lras_rsp_if
   import lras_pkg::*;
   #(parameter int COORD_BITS = COORD_BITS_DEF)
   ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic [COLOR_BITS-1:0] pixel_color;
   logic                  last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                   input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                   output ready);
endinterface

`default_nettype wire

// ===== design/lras_queue.sv =====
// Small register queue between the front and back parts.
`default_nettype none

module lras_queue
   import lras_pkg::*;
   #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
   )
   (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output qstat_type             status,
   output logic      [WIDTH-1:0] pop_data
   );

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   // Pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== design/lras_front.sv =====
// Front part: accepts items and works out the line setup for loads.
`default_nettype none

module lras_front
   import lras_pkg::*;
   #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int ENTRY_BITS = 1 + 5 * COORD_BITS + 4 + COLOR_BITS
   )
   (
   lras_req_if.sink              req_bus,
   input  wire qstat_type        status,
   output logic                  push,
   output logic [ENTRY_BITS-1:0] push_data
   );

   logic [COORD_BITS-1:0] abs_dcol;
   logic [COORD_BITS-1:0] abs_drow;
   logic [COORD_BITS-1:0] major_len;
   dir_type               col_dir;
   dir_type               row_dir;

   // Per-axis length and direction
   always_comb begin
      if (req_bus.end_x > req_bus.start_x) begin
         abs_dcol = req_bus.end_x - req_bus.start_x;
         col_dir  = DIR_PLUS;
      end else if (req_bus.end_x < req_bus.start_x) begin
         abs_dcol = req_bus.start_x - req_bus.end_x;
         col_dir  = DIR_MINUS;
      end else begin
         abs_dcol = '0;
         col_dir  = DIR_NONE;
      end
      if (req_bus.end_y > req_bus.start_y) begin
         abs_drow = req_bus.end_y - req_bus.start_y;
         row_dir  = DIR_PLUS;
      end else if (req_bus.end_y < req_bus.start_y) begin
         abs_drow = req_bus.start_y - req_bus.end_y;
         row_dir  = DIR_MINUS;
      end else begin
         abs_drow = '0;
         row_dir  = DIR_NONE;
      end
      major_len = (abs_dcol > abs_drow) ? abs_dcol : abs_drow;
   end

   // Enqueue on accept; step items carry don't-care setup fields
   assign req_bus.ready = !status.full;
   assign push          = req_bus.valid && !status.full;
   assign push_data     = {req_bus.cmd, req_bus.start_x, req_bus.start_y,
                           abs_dcol, abs_drow, major_len,
                           col_dir, row_dir, req_bus.pen_color};

endmodule

`default_nettype wire

// ===== design/lras_back.sv =====
// Back part: holds the line state, steps the error accumulators, emits pixels.
`default_nettype none

module lras_back
   import lras_pkg::*;
   #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int ENTRY_BITS = 1 + 5 * COORD_BITS + 4 + COLOR_BITS
   )
   (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire qstat_type             status,
   input  wire logic [ENTRY_BITS-1:0] pop_data,
   output logic                       pop,
   lras_rsp_if.source                 rsp_bus
   );

   localparam int ERR_BITS  = COORD_BITS + 2;
   localparam int LEFT_BITS = COORD_BITS + 1;

   // Queue entry fields
   logic                  e_cmd;
   logic [COORD_BITS-1:0] e_sx, e_sy, e_dcol, e_drow, e_major;
   logic [1:0]            e_cdir, e_rdir;
   logic [COLOR_BITS-1:0] e_color;

   assign {e_cmd, e_sx, e_sy, e_dcol, e_drow, e_major, e_cdir, e_rdir, e_color} = pop_data;

   // Line state
   logic [COORD_BITS-1:0] cur_col_ff, cur_col_in;
   logic [COORD_BITS-1:0] cur_row_ff, cur_row_in;
   logic [ERR_BITS-1:0]   col_err_ff, col_err_in;
   logic [ERR_BITS-1:0]   row_err_ff, row_err_in;
   logic [COORD_BITS-1:0] abs_dcol_ff, abs_dcol_in;
   logic [COORD_BITS-1:0] abs_drow_ff, abs_drow_in;
   logic [COORD_BITS-1:0] major_len_ff, major_len_in;
   logic [1:0]            col_dir_ff, col_dir_in;
   logic [1:0]            row_dir_ff, row_dir_in;
   logic [LEFT_BITS-1:0]  pixels_left_ff, pixels_left_in;
   logic [COLOR_BITS-1:0] line_color_ff, line_color_in;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [COLOR_BITS-1:0] rsp_color_ff;
   logic                  rsp_last_ff;

   logic                  out_busy;
   logic                  emit;
   logic [ERR_BITS-1:0]   major_ext;
   logic [ERR_BITS-1:0]   col_sum, row_sum;

   function automatic logic [COORD_BITS-1:0] move_coord(logic [COORD_BITS-1:0] pos,
                                                        logic [1:0] dir);
      logic [COORD_BITS-1:0] res;
      case (dir)
         DIR_PLUS:  res = pos + 1'b1;
         DIR_MINUS: res = pos - 1'b1;
         default:   res = pos;
      endcase
      return res;
   endfunction

   // Pop a load whenever present; a step only when the output slot frees up
   assign out_busy = rsp_valid_ff && !rsp_bus.ready;
   assign pop      = !status.empty && ((cmd_type'(e_cmd) == CMD_LOAD) || !out_busy);
   assign emit     = pop && (cmd_type'(e_cmd) == CMD_STEP) && (pixels_left_ff != '0);

   assign major_ext = {2'b00, major_len_ff};
   assign col_sum   = col_err_ff + {2'b00, abs_dcol_ff};
   assign row_sum   = row_err_ff + {2'b00, abs_drow_ff};

   // Next line state
   always_comb begin
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      col_err_in     = col_err_ff;
      row_err_in     = row_err_ff;
      abs_dcol_in    = abs_dcol_ff;
      abs_drow_in    = abs_drow_ff;
      major_len_in   = major_len_ff;
      col_dir_in     = col_dir_ff;
      row_dir_in     = row_dir_ff;
      pixels_left_in = pixels_left_ff;
      line_color_in  = line_color_ff;
      if (pop && (cmd_type'(e_cmd) == CMD_LOAD)) begin
         cur_col_in     = e_sx;
         cur_row_in     = e_sy;
         col_err_in     = '0;
         row_err_in     = '0;
         abs_dcol_in    = e_dcol;
         abs_drow_in    = e_drow;
         major_len_in   = e_major;
         col_dir_in     = e_cdir;
         row_dir_in     = e_rdir;
         pixels_left_in = {1'b0, e_major} + 1'b1;
         line_color_in  = e_color;
      end else if (emit) begin
         // Axis advances only when its accumulator strictly exceeds the major length
         col_err_in = col_sum;
         row_err_in = row_sum;
         if (col_sum > major_ext) begin
            col_err_in = col_sum - major_ext;
            cur_col_in = move_coord(cur_col_ff, col_dir_ff);
         end
         if (row_sum > major_ext) begin
            row_err_in = row_sum - major_ext;
            cur_row_in = move_coord(cur_row_ff, row_dir_ff);
         end
         pixels_left_in = pixels_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_left_ff <= '0;
      end else begin
         pixels_left_ff <= pixels_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         col_err_ff    <= '0;
         row_err_ff    <= '0;
         abs_dcol_ff   <= '0;
         abs_drow_ff   <= '0;
         major_len_ff  <= '0;
         col_dir_ff    <= DIR_NONE;
         row_dir_ff    <= DIR_NONE;
         line_color_ff <= '0;
      end else begin
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         col_err_ff    <= col_err_in;
         row_err_ff    <= row_err_in;
         abs_dcol_ff   <= abs_dcol_in;
         abs_drow_ff   <= abs_drow_in;
         major_len_ff  <= major_len_in;
         col_dir_ff    <= col_dir_in;
         row_dir_ff    <= row_dir_in;
         line_color_ff <= line_color_in;
      end
   end

   // Output register handshake
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x_ff     <= cur_col_ff;
         rsp_y_ff     <= cur_row_ff;
         rsp_color_ff <= line_color_ff;
         rsp_last_ff  <= (pixels_left_ff == LEFT_BITS'(1));
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_x     = rsp_x_ff;
   assign rsp_bus.pixel_y     = rsp_y_ff;
   assign rsp_bus.pixel_color = rsp_color_ff;
   assign rsp_bus.last_pixel  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/line_rasterizer.sv =====
// Line rasterizer top level: front, queue and back.
//
// Request channel req_bus: cmd 0 loads a line (end points and colour),
// cmd 1 asks for the next pixel. Pixel channel rsp_bus: one item per step
// item while the line lasts, last_pixel set on the final one; a line of
// length L gives L+1 pixels. Loads and steps past the end give nothing.
// Throughput: one item per cycle in steady state while the receiver is ready;
// the back part pops one queue entry per cycle and each step is a pair of adds and compares.
// An accepted step item is written into the queue; once popped, its pixel is
// registered in the output register, which drives rsp_bus.
// A two-entry queue parts the front from the back, so request acceptance
// does not wait on the pixel receiver until the queue fills.
// Receiver stall: the output register holds its pixel, step items back up
// in the queue and req_bus.ready falls when the queue is full.
// Reset (synchronous, active high): queue emptied, output invalid, no line
// active; steps before the first load give nothing.
`default_nettype none

module line_rasterizer
   import lras_pkg::*;
   #(
   parameter int COORD_BITS = COORD_BITS_DEF
   )
   (
   input  wire logic  clock,
   input  wire logic  reset,
   lras_req_if.sink   req_bus,
   lras_rsp_if.source rsp_bus
   );

   localparam int ENTRY_BITS = 1 + 5 * COORD_BITS + 4 + COLOR_BITS;

   qstat_type             status;
   logic                  push;
   logic                  pop;
   logic [ENTRY_BITS-1:0] push_data;
   logic [ENTRY_BITS-1:0] pop_data;

   lras_front #(
      .COORD_BITS (COORD_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_front (
      .req_bus   (req_bus),
      .status    (status),
      .push      (push),
      .push_data (push_data)
   );

   lras_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .status    (status),
      .pop_data  (pop_data)
   );

   lras_back #(
      .COORD_BITS (COORD_BITS),
      .ENTRY_BITS (ENTRY_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .status   (status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for line_rasterizer: directed and random lines, pixel predictor.
`default_nettype none

module testbench;
   import lras_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = COORD_BITS_DEF;
   localparam int COORD_MAX = (1 << CB) - 1;
   localparam int LONG_SPAN = 255;

   // One request item as the sender drives it
   typedef struct {
      cmd_type               cmd;
      logic [CB-1:0]         start_x;
      logic [CB-1:0]         start_y;
      logic [CB-1:0]         end_x;
      logic [CB-1:0]         end_y;
      logic [COLOR_BITS-1:0] pen_color;
   } line_cmd_type;

   // One pixel item as the block should give it
   typedef struct {
      logic [CB-1:0]         x;
      logic [CB-1:0]         y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset;

   lras_req_if #(.COORD_BITS(CB)) req_bus ();
   lras_rsp_if #(.COORD_BITS(CB)) rsp_bus ();

   line_rasterizer #(.COORD_BITS(CB)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted line state
   logic [CB-1:0]         cur_col     = '0;
   logic [CB-1:0]         cur_row     = '0;
   logic [CB+1:0]         col_err     = '0;
   logic [CB+1:0]         row_err     = '0;
   logic [CB-1:0]         abs_dcol    = '0;
   logic [CB-1:0]         abs_drow    = '0;
   logic [CB-1:0]         major_len   = '0;
   dir_type               col_dir     = DIR_NONE;
   dir_type               row_dir     = DIR_NONE;
   logic [CB:0]           pixels_left = '0;
   logic [COLOR_BITS-1:0] line_color  = '0;

   pixel_type pending_pixels[$];
   int        failures      = 0;
   int        counted_items = 0;
   bit        no_idle       = 1'b0;

   // Length and direction of one axis
   function automatic void axis_setup(input logic [CB-1:0] from, input logic [CB-1:0] to,
                                      output logic [CB-1:0] len, output dir_type dir);
      if (to > from) begin
         len = to - from;
         dir = DIR_PLUS;
      end else if (to < from) begin
         len = from - to;
         dir = DIR_MINUS;
      end else begin
         len = '0;
         dir = DIR_NONE;
      end
   endfunction

   function automatic logic [CB-1:0] step_coord(input logic [CB-1:0] pos, input dir_type dir);
      case (dir)
         DIR_PLUS:  return pos + 1'b1;
         DIR_MINUS: return pos - 1'b1;
         default:   return pos;
      endcase
   endfunction

   // Advance the predicted state by one accepted item, queue any pixel it gives
   task automatic rasterize_item(input line_cmd_type it);
      pixel_type px;
      if (it.cmd == CMD_LOAD) begin
         axis_setup(it.start_x, it.end_x, abs_dcol, col_dir);
         axis_setup(it.start_y, it.end_y, abs_drow, row_dir);
         major_len   = (abs_dcol > abs_drow) ? abs_dcol : abs_drow;
         cur_col     = it.start_x;
         cur_row     = it.start_y;
         col_err     = '0;
         row_err     = '0;
         pixels_left = major_len + 1'b1;
         line_color  = it.pen_color;
         counted_items++;
      end else if (pixels_left != 0) begin
         px.x     = cur_col;
         px.y     = cur_row;
         px.color = line_color;
         px.last  = (pixels_left == 1);
         pending_pixels.push_back(px);
         // strict compare: the major axis lags by one
         col_err = col_err + abs_dcol;
         row_err = row_err + abs_drow;
         if (col_err > major_len) begin
            col_err = col_err - major_len;
            cur_col = step_coord(cur_col, col_dir);
         end
         if (row_err > major_len) begin
            row_err = row_err - major_len;
            cur_row = step_coord(cur_row, row_dir);
         end
         pixels_left = pixels_left - 1'b1;
         counted_items++;
      end
   endtask

   function automatic line_cmd_type make_load(input int sx, input int sy, input int ex,
                                              input int ey, input int color);
      line_cmd_type it;
      it.cmd       = CMD_LOAD;
      it.start_x   = CB'(sx);
      it.start_y   = CB'(sy);
      it.end_x     = CB'(ex);
      it.end_y     = CB'(ey);
      it.pen_color = COLOR_BITS'(color);
      return it;
   endfunction

   // Step item; the unused fields carry noise
   function automatic line_cmd_type random_step();
      line_cmd_type it;
      it           = make_load($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                               $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                               $urandom_range(16'hFFFF));
      it.cmd       = CMD_STEP;
      return it;
   endfunction

   // Send one item, with a random gap before it
   task automatic send_item(input line_cmd_type it);
      while (!no_idle && $urandom_range(99) < 11) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= it.cmd;
      req_bus.start_x   <= it.start_x;
      req_bus.start_y   <= it.start_y;
      req_bus.end_x     <= it.end_x;
      req_bus.end_y     <= it.end_y;
      req_bus.pen_color <= it.pen_color;
      do @(posedge clock); while (!req_bus.ready);
      rasterize_item(it);
   endtask

   task automatic send_steps(input int count);
      repeat (count) send_item(random_step());
   endtask

   // Hold the sender until every pending pixel has arrived, then report any that never did
   task automatic wait_drained();
      int waited;
      waited = 0;
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         $error("%0d pixel items never arrived", pending_pixels.size());
         failures += pending_pixels.size();
         pending_pixels.delete();
      end
   endtask

   // Receiver stalls at random unless the no-idle stretch is on
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= no_idle || ($urandom_range(99) >= 11);
      end
   end

   // Compare each accepted pixel with the oldest prediction
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel item (%0d,%0d) with none expected", rsp_bus.pixel_x, rsp_bus.pixel_y);
            failures++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_bus.pixel_x !== want.x) begin
               $error("pixel_x: expected %0d, got %0d", want.x, rsp_bus.pixel_x);
               failures++;
            end
            if (rsp_bus.pixel_y !== want.y) begin
               $error("pixel_y: expected %0d, got %0d", want.y, rsp_bus.pixel_y);
               failures++;
            end
            if (rsp_bus.pixel_color !== want.color) begin
               $error("pixel_color: expected %h, got %h", want.color, rsp_bus.pixel_color);
               failures++;
            end
            if (rsp_bus.last_pixel !== want.last) begin
               $error("last_pixel: expected %0d, got %0d", want.last, rsp_bus.last_pixel);
               failures++;
            end
         end
      end
   end

   // Steps with no line loaded give nothing
   task automatic test_idle_steps();
      send_steps(2);
   endtask

   // Equal end points: one pixel, marked last, then nothing
   task automatic test_single_point();
      send_item(make_load(0, 0, 0, 0, 16'hFFFF));
      send_steps(2);
      send_item(make_load(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'h0000));
      send_steps(1);
   endtask

   // Corner to corner, cut short by a new load, then a short line run past its end
   task automatic test_extreme_corners();
      send_item(make_load(0, COORD_MAX, COORD_MAX, 0, 16'hFFFF));
      send_steps(3);
      send_item(make_load(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX, 16'h0000));
      send_steps(5);
   endtask

   task automatic test_vertical();
      send_item(make_load(512, 0, 512, 2, 16'hA5A5));
      send_steps(3);
   endtask

   // Long diagonal with no idling on either side
   task automatic test_longest_line();
      no_idle = 1'b1;
      send_item(make_load(0, COORD_MAX, LONG_SPAN, COORD_MAX - LONG_SPAN, 16'h5A5A));
      send_steps(LONG_SPAN + 2);
      no_idle = 1'b0;
   endtask

   // Mostly whole short lines with random content, some cut short, some run past the end
   task automatic test_random_lines();
      int sx, sy, ex, ey, span, steps, long_left, line_count, target;
      long_left  = 2;
      line_count = 0;
      target     = counted_items + 200;
      while (counted_items < target) begin
         if ($urandom_range(9) == 0)
            send_item(random_step());
         sx = $urandom_range(COORD_MAX);
         sy = $urandom_range(COORD_MAX);
         if (long_left > 0 && $urandom_range(63) == 0) begin
            ex = sx + $urandom_range(254) - 127;
            ey = sy + $urandom_range(254) - 127;
            long_left--;
         end else begin
            ex = sx + $urandom_range(30) - 15;
            ey = sy + $urandom_range(30) - 15;
         end
         ex = (ex < 0) ? 0 : (ex > COORD_MAX) ? COORD_MAX : ex;
         ey = (ey < 0) ? 0 : (ey > COORD_MAX) ? COORD_MAX : ey;
         span = (ex > sx) ? ex - sx : sx - ex;
         if (((ey > sy) ? ey - sy : sy - ey) > span)
            span = (ey > sy) ? ey - sy : sy - ey;
         case ($urandom_range(15))
            0:       steps = $urandom_range(span);
            1, 2, 3: steps = span + 1 + $urandom_range(3, 1);
            default: steps = span + 1;
         endcase
         no_idle = (line_count >= 20 && line_count < 30);
         send_item(make_load(sx, sy, ex, ey, $urandom_range(16'hFFFF)));
         send_steps(steps);
         line_count++;
         if (line_count == 10)
            wait_drained();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_LOAD;
      req_bus.start_x   = '0;
      req_bus.start_y   = '0;
      req_bus.end_x     = '0;
      req_bus.end_y     = '0;
      req_bus.pen_color = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_steps();
      test_single_point();
      test_extreme_corners();
      test_vertical();
      wait_drained();
      test_longest_line();
      test_random_lines();
      wait_drained();

      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Run limit
   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire
